### src/btpq_pkg.sv
// ----------------------------------------------------------------------------
// btpq_pkg
// Types and fixed constants shared by the box tolerance point query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpq_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W    = 32;   // signed Q16.16 coordinate
  localparam int FRAC_W     = 16;   // fraction bits of a coordinate
  localparam int REL_W      = 24;   // rel_tol, unsigned Q8.16
  localparam int ABS_W      = 31;   // abs_tol, unsigned Q15.16
  localparam int IDX_OUT_W  = 6;    // element_index on the result channel
  localparam int BOX_WORDS  = 6;    // min x,y,z then max x,y,z
  localparam int BOX_W      = BOX_WORDS * COORD_W;
  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int OUT_DATA_W = 8;

  // At most this many hits are reported for one query.
  localparam int RESULT_CAP = 64;
  localparam int HIT_CNT_W  = 7;

  // Arithmetic widths of the containment test.
  localparam int DIFF_W = COORD_W + 1;            // difference of two coordinates
  localparam int PROD_W = DIFF_W + REL_W + 1;     // size times rel_tol, Q.32
  localparam int TOL_W  = PROD_W + 1;             // tolerance, Q.32
  localparam int SUM_W  = TOL_W + 1;              // shifted difference plus tolerance

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_ADDR_W-1:0] CFG_REL_TOL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ABS_TOL = 1'd1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_HIT      = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Result of the containment test leaving the arithmetic pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
  } hit_t;

endpackage

### src/box_tolerance_point_query.sv
// ----------------------------------------------------------------------------
// box_tolerance_point_query
// Store of axis-aligned boxes with a tolerant point-containment query.
// ----------------------------------------------------------------------------
// Usage.
// The input stream carries the action in in_tuser and the box or point in
// in_tdata. An insert appends a box, a clear empties the store, and each
// answers with one transfer of status done (or store full) and tlast set,
// loaded into the output register at the input transfer and shown on the
// next cycle. A query scans the stored boxes in insertion order through the
// box memory's single read port, one box per cycle while the output does not
// stall, into a four-stage test pipeline; it yields one hit transfer per
// containing box, at most 64, the final one marked by tlast, or a single
// no-match transfer. No input is taken while a query scans. rel_tol and
// abs_tol are to be written on the cfg port while the block is idle; the
// block itself does not enforce this. Reset empties the store and zeroes the
// tolerances at once; box contents are left undefined, so there is no
// clearing pass. When the receiver stalls, the output register holds its
// transfer and the scan pipeline holds with it, so nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_tolerance_point_query #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_tdata, lowest bit up: box_min_x, box_min_y, box_min_z, box_max_x,
  // box_max_y, box_max_z, query_x, query_y, query_z (32 bits each).
  input  logic [btpq_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: action (2 bits).
  input  logic [1:0]                           in_tuser,
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata, lowest bit up: element_index (6 bits), 2 bits of zero.
  output logic [btpq_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: status (2 bits).
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [btpq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [btpq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [btpq_pkg::HIT_CNT_W-1:0] HIT_CAP =
    btpq_pkg::HIT_CNT_W'(btpq_pkg::RESULT_CAP);
  localparam int CW = btpq_pkg::COORD_W;

  btpq_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [btpq_pkg::HIT_CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [AW-1:0]    pend_idx_r, pend_idx_nxt;

  logic [btpq_pkg::REL_W-1:0] rel_tol_r;
  logic [btpq_pkg::ABS_W-1:0] abs_tol_r;
  logic [CW-1:0]    point_x_r, point_y_r, point_z_r;

  logic                            out_valid_r, out_valid_nxt;
  btpq_pkg::status_t               out_status_r, out_status_nxt;
  logic [btpq_pkg::IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [btpq_pkg::BOX_W-1:0] box_mem [MAX_ELEMENTS];
  logic [btpq_pkg::BOX_W-1:0] rd_box_r;
  logic                       v0_r;
  logic [AW-1:0]              idx0_r;

  logic                       adv;
  logic                       accept;
  logic                       mem_we;
  logic                       issue;
  logic                       latch_point;
  btpq_pkg::hit_t             res;
  logic [AW-1:0]              res_idx;
  logic                       busy;

  // The result register is free, or frees itself this cycle.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = (state_r == btpq_pkg::S_IDLE) && adv;
  assign accept    = in_tvalid && in_tready;

  // Next state, store bookkeeping and result loading.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    hit_cnt_nxt    = hit_cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    issue          = 1'b0;
    latch_point    = 1'b0;

    case (state_r)
      btpq_pkg::S_IDLE: begin
        if (accept) begin
          case (btpq_pkg::action_t'(in_tuser))
            btpq_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_last_nxt  = 1'b1;
              if (count_r >= MAX_CNT) begin
                out_status_nxt = btpq_pkg::ST_FULL;
              end else begin
                out_status_nxt = btpq_pkg::ST_DONE;
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            btpq_pkg::ACT_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = btpq_pkg::ST_DONE;
              out_idx_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            btpq_pkg::ACT_QUERY: begin
              latch_point = 1'b1;
              scan_nxt    = '0;
              hit_cnt_nxt = '0;
              pend_v_nxt  = 1'b0;
              state_nxt   = btpq_pkg::S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      btpq_pkg::S_SCAN: begin
        if (adv) begin
          // Feed the next stored box into the read port.
          if (scan_r < count_r) begin
            issue    = 1'b1;
            scan_nxt = scan_r + 1'b1;
          end
          // A new hit sends the previous one on; it is not the last.
          if (res.valid && res.hit && (hit_cnt_r < HIT_CAP)) begin
            hit_cnt_nxt  = hit_cnt_r + 1'b1;
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = res_idx;
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = btpq_pkg::ST_HIT;
              out_idx_nxt    = btpq_pkg::IDX_OUT_W'(pend_idx_r);
              out_last_nxt   = 1'b0;
            end
          end
          // Scan drained: close with the held hit or a no-match.
          if ((scan_r >= count_r) && !v0_r && !busy) begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b1;
            state_nxt      = btpq_pkg::S_IDLE;
            if (pend_v_r) begin
              out_status_nxt = btpq_pkg::ST_HIT;
              out_idx_nxt    = btpq_pkg::IDX_OUT_W'(pend_idx_r);
            end else begin
              out_status_nxt = btpq_pkg::ST_NO_MATCH;
              out_idx_nxt    = '0;
            end
          end
        end
      end

      default: begin
        state_nxt = btpq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btpq_pkg::S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      hit_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      v0_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) v0_r <= issue;
    end
  end

  // Result payload, held hit index and query point.
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    if (latch_point) begin
      point_x_r <= in_tdata[6*CW +: CW];
      point_y_r <= in_tdata[7*CW +: CW];
      point_z_r <= in_tdata[8*CW +: CW];
    end
  end

  // Tolerance registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_tol_r <= '0;
      abs_tol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        btpq_pkg::CFG_REL_TOL: rel_tol_r <= cfg_wdata[btpq_pkg::REL_W-1:0];
        btpq_pkg::CFG_ABS_TOL: abs_tol_r <= cfg_wdata[btpq_pkg::ABS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Box memory: one row per box, written on insert, read during a scan.
  // Inserts happen only while idle, so a write never meets a scan read.
  always_ff @(posedge clk) begin
    if (mem_we) box_mem[count_r[AW-1:0]] <= in_tdata[btpq_pkg::BOX_W-1:0];
    if (adv) begin
      rd_box_r <= box_mem[scan_r[AW-1:0]];
      idx0_r   <= scan_r[AW-1:0];
    end
  end

  btpq_test_pipe #(
    .IDX_W (AW)
  ) u_test_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .box_valid (v0_r),
    .box_idx   (idx0_r),
    .box       (rd_box_r),
    .point_x   (point_x_r),
    .point_y   (point_y_r),
    .point_z   (point_z_r),
    .rel_tol   (rel_tol_r),
    .abs_tol   (abs_tol_r),
    .res       (res),
    .res_idx   (res_idx),
    .busy      (busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = btpq_pkg::OUT_DATA_W'(out_idx_r);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### src/btpq_test_pipe.sv
// ----------------------------------------------------------------------------
// btpq_test_pipe
// Four-stage pipeline that tests one box per cycle unless stalled, against
// the point: extents and differences, size times rel_tol, tolerance, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpq_test_pipe #(
  parameter int IDX_W = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                box_valid,
  input  logic [IDX_W-1:0]                    box_idx,
  input  logic [btpq_pkg::BOX_W-1:0]          box,
  input  logic [btpq_pkg::COORD_W-1:0]        point_x,
  input  logic [btpq_pkg::COORD_W-1:0]        point_y,
  input  logic [btpq_pkg::COORD_W-1:0]        point_z,
  input  logic [btpq_pkg::REL_W-1:0]          rel_tol,
  input  logic [btpq_pkg::ABS_W-1:0]          abs_tol,
  output btpq_pkg::hit_t                      res,
  output logic [IDX_W-1:0]                    res_idx,
  output logic                                busy
);

  localparam int CW  = btpq_pkg::COORD_W;
  localparam int DW  = btpq_pkg::DIFF_W;
  localparam int PW  = btpq_pkg::PROD_W;
  localparam int TW  = btpq_pkg::TOL_W;
  localparam int SW  = btpq_pkg::SUM_W;
  localparam int FW  = btpq_pkg::FRAC_W;
  localparam int ASW = btpq_pkg::ABS_W + btpq_pkg::FRAC_W;

  logic signed [DW-1:0] dlo_c [3];
  logic signed [DW-1:0] dhi_c [3];
  logic signed [DW-1:0] ext_c [3];
  logic signed [DW-1:0] size_c;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [DW-1:0] s1_size_r;
  logic signed [DW-1:0] s1_dlo_r [3];
  logic signed [DW-1:0] s1_dhi_r [3];
  logic signed [PW-1:0] s2_prod_r;
  logic signed [DW-1:0] s2_dlo_r [3];
  logic signed [DW-1:0] s2_dhi_r [3];
  logic signed [TW-1:0] s3_tol_r;
  logic signed [DW-1:0] s3_dlo_r [3];
  logic signed [DW-1:0] s3_dhi_r [3];
  logic                 s4_hit_r;

  logic signed [btpq_pkg::REL_W:0] rel_s;
  logic signed [TW-1:0]            abs_s;
  logic                            hit_c;

  // Stage one: extents of the box and the point's distance to each face.
  always_comb begin
    logic [CW-1:0] lo_w;
    logic [CW-1:0] hi_w;
    logic [CW-1:0] p_w;
    lo_w = '0;
    hi_w = '0;
    p_w  = '0;
    for (int k = 0; k < 3; k++) begin
      lo_w = box[k*CW +: CW];
      hi_w = box[(3+k)*CW +: CW];
      case (k)
        0:       p_w = point_x;
        1:       p_w = point_y;
        default: p_w = point_z;
      endcase
      ext_c[k] = $signed({hi_w[CW-1], hi_w}) - $signed({lo_w[CW-1], lo_w});
      dlo_c[k] = $signed({p_w[CW-1], p_w}) - $signed({lo_w[CW-1], lo_w});
      dhi_c[k] = $signed({hi_w[CW-1], hi_w}) - $signed({p_w[CW-1], p_w});
    end
    size_c = ext_c[0];
    if (ext_c[1] > size_c) size_c = ext_c[1];
    if (ext_c[2] > size_c) size_c = ext_c[2];
  end

  assign rel_s = $signed({1'b0, rel_tol});
  assign abs_s = $signed({{(TW-ASW){1'b0}}, abs_tol, {FW{1'b0}}});

  // Stage four: every face, shifted to Q.32 and widened by the tolerance,
  // must not lie beyond the point.
  always_comb begin
    logic signed [SW-1:0] t_lo;
    logic signed [SW-1:0] t_hi;
    t_lo  = '0;
    t_hi  = '0;
    hit_c = 1'b1;
    for (int k = 0; k < 3; k++) begin
      t_lo = (SW'(s3_dlo_r[k]) <<< FW) + SW'(s3_tol_r);
      t_hi = (SW'(s3_dhi_r[k]) <<< FW) + SW'(s3_tol_r);
      if (t_lo[SW-1] || t_hi[SW-1]) hit_c = 1'b0;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= box_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage payloads; the whole pipeline holds while the result side stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r    <= box_idx;
      idx2_r    <= idx1_r;
      idx3_r    <= idx2_r;
      idx4_r    <= idx3_r;
      s1_size_r <= size_c;
      s2_prod_r <= s1_size_r * rel_s;
      s3_tol_r  <= TW'(s2_prod_r) + abs_s;
      s4_hit_r  <= hit_c;
      for (int k = 0; k < 3; k++) begin
        s1_dlo_r[k] <= dlo_c[k];
        s1_dhi_r[k] <= dhi_c[k];
        s2_dlo_r[k] <= s1_dlo_r[k];
        s2_dhi_r[k] <= s1_dhi_r[k];
        s3_dlo_r[k] <= s2_dlo_r[k];
        s3_dhi_r[k] <= s2_dhi_r[k];
      end
    end
  end

  assign res.valid = v4_r;
  assign res.hit   = s4_hit_r;
  assign res_idx   = idx4_r;
  assign busy      = v1_r | v2_r | v3_r | v4_r;

endmodule

### src/btpq_checker.sv
// ----------------------------------------------------------------------------
// btpq_checker
// Port-level checks of the box tolerance point query block, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [1:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [btpq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);

  // Only a hit can be followed by more results of the same item.
  a_nonhit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != btpq_pkg::ST_HIT)) |-> out_tlast)
    else $error("non-hit result without tlast");

  // Results other than hits carry index zero.
  a_nonhit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != btpq_pkg::ST_HIT)) |-> (out_tdata == '0))
    else $error("non-hit result with a nonzero index");

  // Input is taken only when the result register can accept a result.
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input ready while the result register is blocked");

  // An insert or clear transfer is answered on the next cycle.
  a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     ((in_tuser == btpq_pkg::ACT_INSERT) || (in_tuser == btpq_pkg::ACT_CLEAR)))
    |=> (out_tvalid && out_tlast &&
         ((out_tuser == btpq_pkg::ST_DONE) || (out_tuser == btpq_pkg::ST_FULL))))
    else $error("insert or clear not answered");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
    (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind box_tolerance_point_query btpq_checker u_btpq_checker (.*);

### bench/box_tolerance_point_query_tb.sv
// ----------------------------------------------------------------------------
// box_tolerance_point_query_tb
// Self-checking bench for the tolerant point-in-box query block.
// ----------------------------------------------------------------------------
// Boxes, clears and point queries are streamed into the block. A behavioural
// copy of the box store works out the status, index and last flag that each
// accepted transfer should cause. Every result transfer is then checked in
// order against those expectations. Directed cases cover the corners of the
// coordinate range, inverted and degenerate boxes, the full store and the
// ignored action code. Random phases follow, each with its own tolerance
// setting and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_tolerance_point_query_tb;
  import btpq_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 16;
  localparam int MAX_REPORTS = 10;
  localparam longint FRAC_SCALE = 65536;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

  // Payload of one input transfer, packed as on in_tdata.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic [2:0][COORD_W-1:0] hi;
    logic [2:0][COORD_W-1:0] lo;
  } item_data_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Behavioural copy of the block state.
  logic [2:0][COORD_W-1:0] shadow_lo [STORE_DEPTH];
  logic [2:0][COORD_W-1:0] shadow_hi [STORE_DEPTH];
  int unsigned             shadow_count = 0;
  logic [REL_W-1:0]        shadow_rel_tol = '0;
  logic [ABS_W-1:0]        shadow_abs_tol = '0;

  result_t      due_results [$];
  int unsigned  mismatch_count = 0;
  int           tx_gap_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_cycles = 0;
  logic [31:0]  region_base = '0;

  box_tolerance_point_query #(
    .MAX_ELEMENTS(STORE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact containment test of stored box e, widened by its tolerance.
  function automatic bit box_contains(int unsigned e, item_data_t item);
    longint lo [3];
    longint hi [3];
    longint p [3];
    longint extent;
    longint tol;
    for (int k = 0; k < 3; k++) begin
      lo[k] = longint'($signed(shadow_lo[e][k]));
      hi[k] = longint'($signed(shadow_hi[e][k]));
      p[k]  = longint'($signed(item.point[k]));
    end
    extent = hi[0] - lo[0];
    if (hi[1] - lo[1] > extent) extent = hi[1] - lo[1];
    if (hi[2] - lo[2] > extent) extent = hi[2] - lo[2];
    tol = extent * longint'(shadow_rel_tol) + longint'(shadow_abs_tol) * FRAC_SCALE;
    for (int k = 0; k < 3; k++) begin
      if ((p[k] - lo[k]) * FRAC_SCALE + tol < 0) return 1'b0;
      if ((hi[k] - p[k]) * FRAC_SCALE + tol < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Append one expected result behind those already due.
  function automatic void queue_result(result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  // Update the shadow store for one accepted transfer and queue its results.
  function automatic void record_item(logic [1:0] act, item_data_t item);
    result_t     r;
    int unsigned hits;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= STORE_DEPTH) begin
          queue_result('{ST_FULL, '0, 1'b1});
        end else begin
          shadow_lo[shadow_count] = item.lo;
          shadow_hi[shadow_count] = item.hi;
          shadow_count++;
          queue_result('{ST_DONE, '0, 1'b1});
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        queue_result('{ST_DONE, '0, 1'b1});
      end
      ACT_QUERY: begin
        hits = 0;
        for (int unsigned e = 0; e < shadow_count && hits < RESULT_CAP; e++) begin
          if (box_contains(e, item)) begin
            queue_result('{ST_HIT, IDX_OUT_W'(e), 1'b0});
            hits++;
          end
        end
        if (hits == 0) begin
          queue_result('{ST_NO_MATCH, '0, 1'b1});
        end else begin
          r = due_results.pop_back();
          r.last = 1'b1;
          queue_result(r);
        end
      end
      default: ;  // the unused code is ignored by the block
    endcase
  endfunction

  // Offer one transfer, with random sender gaps, and predict once it is taken.
  task automatic send_item(logic [1:0] act, item_data_t item);
    while ($urandom_range(99) < tx_gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
    record_item(act, item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Drain, then allow for a scan that produces no further transfer.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_REL_TOL) shadow_rel_tol = value[REL_W-1:0];
    else shadow_abs_tol = value[ABS_W-1:0];
  endtask

  function automatic item_data_t random_data();
    item_data_t d;
    for (int k = 0; k < 3; k++) begin
      d.lo[k]    = $urandom();
      d.hi[k]    = $urandom();
      d.point[k] = $urandom();
    end
    return d;
  endfunction

  function automatic item_data_t box_of(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                        logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    item_data_t d;
    d = random_data();
    d.lo = {lz, ly, lx};
    d.hi = {hz, hy, hx};
    return d;
  endfunction

  function automatic item_data_t point_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    item_data_t d;
    d = random_data();
    d.point = {z, y, x};
    return d;
  endfunction

  // Mostly small boxes around the current region, some inverted, some wild.
  function automatic item_data_t random_box_item();
    item_data_t d;
    d = random_data();
    case ($urandom_range(9))
      0: ;
      1: begin
        for (int k = 0; k < 3; k++) begin
          d.lo[k] = region_base + $urandom_range(1 << 20);
          d.hi[k] = d.lo[k] - $urandom_range(1 << 18, 1);
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          d.lo[k] = region_base + $urandom_range(1 << 20);
          d.hi[k] = d.lo[k] + $urandom_range(1 << 18);
        end
      end
    endcase
    return d;
  endfunction

  // Points mostly near a stored box, so that hits and near misses dominate.
  function automatic item_data_t random_query_item();
    item_data_t  d;
    int unsigned e;
    logic [31:0] span;
    d = random_data();
    if (shadow_count != 0 && $urandom_range(3) != 0) begin
      e = $urandom_range(shadow_count - 1);
      for (int k = 0; k < 3; k++) begin
        span = shadow_hi[e][k] - shadow_lo[e][k];
        if (span > (1 << 20)) span = 1 << 20;
        d.point[k] = shadow_lo[e][k] - (1 << 16) + $urandom_range(span + (1 << 17));
      end
    end
    return d;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = status_t'(out_tuser);
      seen.index  = out_tdata[IDX_OUT_W-1:0];
      seen.last   = out_tlast;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transfer: status %0d index %0d last %0d",
                   $time, seen.status, seen.index, seen.last);
      end else begin
        want = due_results.pop_front();
        if (seen.status !== want.status || seen.index !== want.index ||
            seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected status %0d index %0d last %0d, got %0d %0d %0d",
                     $time, want.status, want.index, want.last,
                     seen.status, seen.index, seen.last);
        end
      end
    end
  end

  // Corner coordinates, inverted and degenerate boxes, the ignored code.
  task automatic test_directed();
    tx_gap_pct   = 8;
    rx_stall_pct = 85;
    write_reg(CFG_REL_TOL, '0);
    write_reg(CFG_ABS_TOL, '0);
    send_item(ACT_QUERY, point_at('0, '0, '0));
    send_item(ACT_UNUSED, random_data());
    send_item(ACT_CLEAR, random_data());
    send_item(ACT_INSERT, box_of(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    send_item(ACT_INSERT, box_of(COORD_MIN, COORD_MIN, COORD_MIN,
                                 COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(ACT_INSERT, box_of(2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    send_item(ACT_INSERT, box_of(3 * Q_ONE, -3 * Q_ONE, '0, 3 * Q_ONE, -3 * Q_ONE, '0));
    send_item(ACT_QUERY, point_at('0, '0, '0));
    send_item(ACT_QUERY, point_at(Q_ONE, Q_ONE, Q_ONE));
    send_item(ACT_QUERY, point_at(Q_ONE + 1, '0, '0));
    send_item(ACT_QUERY, point_at(3 * Q_ONE, -3 * Q_ONE, '0));
    send_item(ACT_QUERY, point_at(Q_ONE + Q_ONE / 2, Q_ONE + Q_ONE / 2, Q_ONE + Q_ONE / 2));
    send_item(ACT_QUERY, point_at(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(ACT_QUERY, point_at(COORD_MIN, COORD_MIN, COORD_MIN));
    settle();
    // Largest tolerances: the inverted box now opens up as well.
    write_reg(CFG_REL_TOL, CFG_DATA_W'(24'hff_ffff));
    write_reg(CFG_ABS_TOL, 31'h7fff_ffff);
    send_item(ACT_QUERY, point_at(Q_ONE + Q_ONE / 2, Q_ONE + Q_ONE / 2, Q_ONE + Q_ONE / 2));
    send_item(ACT_QUERY, point_at(COORD_MAX, COORD_MIN, COORD_MAX));
    send_item(ACT_CLEAR, random_data());
    send_item(ACT_QUERY, point_at('0, '0, '0));
    settle();
  endtask

  // Fill the store behind a long receiver hold-off, overflow it, then hit all.
  task automatic test_store_full();
    item_data_t d;
    tx_gap_pct   = 8;
    rx_stall_pct = 85;
    send_item(ACT_CLEAR, random_data());
    rx_hold_cycles = 400;
    repeat (STORE_DEPTH) begin
      d = random_data();
      for (int k = 0; k < 3; k++) begin
        d.lo[k] = COORD_MIN | $urandom();
        d.hi[k] = COORD_MAX & $urandom();
      end
      send_item(ACT_INSERT, d);
    end
    send_item(ACT_INSERT, random_box_item());
    send_item(ACT_QUERY, point_at('0, '0, '0));
    send_item(ACT_QUERY, random_data());
    send_item(ACT_CLEAR, random_data());
    settle();
  endtask

  // Short well-formed runs of inserts and queries, with some noise mixed in.
  task automatic test_random_phase(int gap_pct, int stall_pct, logic [REL_W-1:0] rel_value,
                                   logic [ABS_W-1:0] abs_value, int n_items);
    int          sent;
    int unsigned n;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    write_reg(CFG_REL_TOL, CFG_DATA_W'(rel_value));
    write_reg(CFG_ABS_TOL, abs_value);
    sent = 0;
    while (sent < n_items) begin
      region_base = $urandom();
      if (shadow_count > 12 || $urandom_range(2) == 0) begin
        send_item(ACT_CLEAR, random_data());
        sent++;
      end
      n = $urandom_range(5, 1);
      repeat (n) begin
        send_item(ACT_INSERT, random_box_item());
        sent++;
      end
      n = $urandom_range(6, 1);
      repeat (n) begin
        send_item(ACT_QUERY, random_query_item());
        sent++;
      end
      if ($urandom_range(4) == 0) send_item(ACT_UNUSED, random_data());
      // Now and then the sender waits for every result before going on.
      if ($urandom_range(5) == 0) wait_drained();
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_store_full();
    test_random_phase(8, 85, 24'h01_0000, 31'h0, 4);
    test_random_phase(85, 8, 24'hff_ffff, 31'h7fff_ffff, 4);
    test_random_phase(0, 0, 24'h00_0800, 31'h0000_4000, 4);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
src/btpq_pkg.sv
src/btpq_test_pipe.sv
src/box_tolerance_point_query.sv
src/btpq_checker.sv
bench/box_tolerance_point_query_tb.sv
